### hw/rtl/prrq_pkg.sv
// Shared types, codes and defaults for the priority round-robin request queues.
package prrq_pkg;

	localparam int NUM_REQUESTERS_DEF = 8;
	localparam int LOWEST_PRIO_DEF    = 3;
	localparam int QUEUE_DEPTH_DEF    = 16;

	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_SRV = 2'd1;
	localparam logic [1:0] KIND_TR  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_QFULL    = 3'd1;
	localparam logic [2:0] ST_TFULL    = 3'd2;
	localparam logic [2:0] ST_NONE     = 3'd3;
	localparam logic [2:0] ST_DISABLED = 3'd4;
	localparam logic [2:0] ST_NOEVENT  = 3'd5;

	localparam logic REG_ENABLE   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;
	localparam logic [4:0] CAP_RESET = 5'd16;

	localparam logic [3:0] OP_IDLE      = 4'd0;
	localparam logic [3:0] OP_LATCH     = 4'd1;
	localparam logic [3:0] OP_ENQ_FIND  = 4'd2;
	localparam logic [3:0] OP_ENQ_PUSH  = 4'd3;
	localparam logic [3:0] OP_SRV_NEXT  = 4'd4;
	localparam logic [3:0] OP_SRV_MISS  = 4'd5;
	localparam logic [3:0] OP_SRV_SEL   = 4'd6;
	localparam logic [3:0] OP_SRV_POP   = 4'd7;
	localparam logic [3:0] OP_SRV_GRANT = 4'd8;
	localparam logic [3:0] OP_TR_NEXT   = 4'd9;
	localparam logic [3:0] OP_TR_SEL    = 4'd10;
	localparam logic [3:0] OP_TR_POP    = 4'd11;
	localparam logic [3:0] OP_TR_PUSH   = 4'd12;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] requester_id;
		logic [1:0]  req_priority;
		logic [15:0] request_count;
		logic [15:0] request_tag;
		logic        event_available;
	} item_t;

	typedef struct packed {
		logic        granted;
		logic [15:0] grant_id;
		logic [1:0]  grant_priority;
		logic [15:0] grant_count;
		logic [15:0] grant_tag;
		logic [3:0]  moved_count;
		logic [2:0]  status;
	} result_t;

	typedef struct packed {
		logic [3:0] op;
		logic       fin;
		logic [2:0] status;
		logic       chk;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       enable;
		logic       cnt_zero;
		logic       new_id_full;
		logic       q_full;
		logic       hit;
		logic       event_ok;
		logic       last_prio;
		logic       tr_skip;
		logic       last_slot;
	} sts_t;

endpackage

### hw/rtl/priority_round_robin_request_queues.sv
// Top level of the strict-priority round-robin request queues.
//
// A transaction is taken when start is high and busy is low; its single result
// appears on result for one cycle with done high, and must be captured then.
// An enqueue finds or inserts the requester and then pushes the request; it ends
// early when a new ID finds the table full. A serve ends with no scan when disabled
// or with an empty table; otherwise it scans priority levels from the highest down
// and, on a grant, pops the request through a queue-memory read. A transition
// steps through the requesters, promoting at most one request from each, with a
// pop and then a push of queue memory per promotion. busy stays high meanwhile.
// Requesters never leave the table, so no clearing pass is needed.
module priority_round_robin_request_queues #(
	parameter int NUM_REQUESTERS = prrq_pkg::NUM_REQUESTERS_DEF,
	parameter int LOWEST_PRIO    = prrq_pkg::LOWEST_PRIO_DEF,
	parameter int QUEUE_DEPTH    = prrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  prrq_pkg::item_t   item,
	output logic              done,
	output prrq_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [4:0]        cfg_data
);
	prrq_pkg::cmd_t cmd;
	prrq_pkg::sts_t sts;

	// sequence each transaction
	prrq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	// table, queues and result
	prrq_dp #(
		.NUM_REQUESTERS(NUM_REQUESTERS),
		.LOWEST_PRIO   (LOWEST_PRIO),
		.QUEUE_DEPTH   (QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result),
		.done     (done)
	);
endmodule

### hw/rtl/prrq_ram.sv
// Generic simple dual-port RAM with registered read.
module prrq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

### hw/rtl/prrq_ctrl.sv
// Controller state machine sequencing enqueue, serve and transition transactions.
module prrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  prrq_pkg::sts_t      sts,
	output prrq_pkg::cmd_t      cmd
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISP     = 4'd1;
	localparam logic [3:0] S_ENQ_FIND = 4'd2;
	localparam logic [3:0] S_ENQ_PUSH = 4'd3;
	localparam logic [3:0] S_SRV_SCAN = 4'd4;
	localparam logic [3:0] S_SRV_POP  = 4'd5;
	localparam logic [3:0] S_SRV_OUT  = 4'd6;
	localparam logic [3:0] S_TR_CHECK = 4'd7;
	localparam logic [3:0] S_TR_POP   = 4'd8;
	localparam logic [3:0] S_TR_PUSH  = 4'd9;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	// next state and datapath command
	always_comb begin
		state_d    = state_q;
		cmd.op     = prrq_pkg::OP_IDLE;
		cmd.fin    = 1'b0;
		cmd.status = prrq_pkg::ST_OK;
		cmd.chk    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = prrq_pkg::OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.kind)
					prrq_pkg::KIND_ENQ: state_d = S_ENQ_FIND;
					prrq_pkg::KIND_SRV: begin
						if (!sts.enable) begin
							cmd.fin    = 1'b1;
							cmd.status = prrq_pkg::ST_DISABLED;
							state_d    = S_IDLE;
						end else if (sts.cnt_zero) begin
							cmd.fin    = 1'b1;
							cmd.status = prrq_pkg::ST_NONE;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SRV_SCAN;
						end
					end
					prrq_pkg::KIND_TR: begin
						if (sts.cnt_zero) begin
							cmd.fin = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_TR_CHECK;
						end
					end
					default: begin
						cmd.fin = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_ENQ_FIND: begin
				if (sts.new_id_full) begin
					cmd.fin    = 1'b1;
					cmd.status = prrq_pkg::ST_TFULL;
					state_d    = S_IDLE;
				end else begin
					cmd.op  = prrq_pkg::OP_ENQ_FIND;
					state_d = S_ENQ_PUSH;
				end
			end
			S_ENQ_PUSH: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
				if (sts.q_full) begin
					cmd.status = prrq_pkg::ST_QFULL;
				end else begin
					cmd.op = prrq_pkg::OP_ENQ_PUSH;
				end
			end
			S_SRV_SCAN: begin
				if (sts.hit) begin
					if (!sts.event_ok) begin
						cmd.op     = prrq_pkg::OP_SRV_MISS;
						cmd.fin    = 1'b1;
						cmd.status = prrq_pkg::ST_NOEVENT;
						state_d    = S_IDLE;
					end else begin
						cmd.op  = prrq_pkg::OP_SRV_SEL;
						state_d = S_SRV_POP;
					end
				end else if (sts.last_prio) begin
					cmd.fin    = 1'b1;
					cmd.status = prrq_pkg::ST_NONE;
					state_d    = S_IDLE;
				end else begin
					cmd.op = prrq_pkg::OP_SRV_NEXT;
				end
			end
			S_SRV_POP: begin
				cmd.op  = prrq_pkg::OP_SRV_POP;
				state_d = S_SRV_OUT;
			end
			S_SRV_OUT: begin
				cmd.op  = prrq_pkg::OP_SRV_GRANT;
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			S_TR_CHECK: begin
				cmd.chk = 1'b1;
				if (sts.tr_skip) begin
					cmd.op = prrq_pkg::OP_TR_NEXT;
					if (sts.last_slot) begin
						cmd.fin = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.op  = prrq_pkg::OP_TR_SEL;
					state_d = S_TR_POP;
				end
			end
			S_TR_POP: begin
				cmd.op  = prrq_pkg::OP_TR_POP;
				state_d = S_TR_PUSH;
			end
			S_TR_PUSH: begin
				cmd.op = prrq_pkg::OP_TR_PUSH;
				if (sts.last_slot) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_TR_CHECK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### hw/rtl/prrq_dp.sv
// Datapath: requester table, queue pointers, queue storage and result register.
module prrq_dp #(
	parameter int NUM_REQUESTERS = prrq_pkg::NUM_REQUESTERS_DEF,
	parameter int LOWEST_PRIO    = prrq_pkg::LOWEST_PRIO_DEF,
	parameter int QUEUE_DEPTH    = prrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  prrq_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [4:0]        cfg_data,
	input  prrq_pkg::cmd_t    cmd,
	output prrq_pkg::sts_t    sts,
	output prrq_pkg::result_t result,
	output logic              done
);
	localparam int N     = NUM_REQUESTERS;
	localparam int NPRIO = LOWEST_PRIO + 1;
	localparam int SW    = (N > 1) ? $clog2(N) : 1;
	localparam int PW    = (NPRIO > 1) ? $clog2(NPRIO) : 1;
	localparam int DW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(N + 1);
	localparam int FW    = $clog2(QUEUE_DEPTH + 1);
	localparam int AW    = SW + PW + DW;

	prrq_pkg::item_t in_q;
	logic            enable_q;
	logic [4:0]      cap_q;
	logic [15:0]     id_q [N];
	logic [SW-1:0]   row_q [N];
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   rr_q, slot_q, qa_row_q;
	logic [PW-1:0]   prio_q, qa_prio_q;
	logic [DW-1:0]   head_q [N][NPRIO];
	logic [DW-1:0]   tail_q [N][NPRIO];
	logic [FW-1:0]   fill_q [N][NPRIO];
	logic [NPRIO-1:0] ne_q [N];
	logic [3:0]      moved_q, moved_nxt;
	prrq_pkg::result_t res_d;

	logic [4:0]      prio_ext;
	logic [PW-1:0]   p_sat;
	logic [CW-1:0]   pos;
	logic            found, tbl_full;
	logic [SW-1:0]   new_row, enq_row;
	logic [SW-1:0]   f_row, tr_row;
	logic [PW-1:0]   f_prio, psel;
	logic [FW-1:0]   fill_cur;
	logic            full_cur, pany, last_slot;
	logic [N-1:0]    cand;
	logic [SW-1:0]   win, win_hi, win_any;
	logic            hit_hi, hit_any;
	logic [DW-1:0]   head_cur, tail_cur, head_nxt, tail_nxt;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [31:0]     ram_wdata, ram_rdata;

	// saturate the request priority
	always_comb begin
		prio_ext = {3'b000, in_q.req_priority};
		p_sat    = (prio_ext > 5'(LOWEST_PRIO)) ? PW'(LOWEST_PRIO) : PW'(prio_ext);
	end

	// sorted table lookup: position is the number of smaller IDs
	always_comb begin
		pos = '0;
		for (int s = 0; s < N; s++) begin
			if ((CW'(s) < cnt_q) && (id_q[s] < in_q.requester_id)) begin
				pos = pos + CW'(1);
			end
		end
		found    = (pos < cnt_q) && (id_q[pos[SW-1:0]] == in_q.requester_id);
		tbl_full = (cnt_q == CW'(N));
		new_row  = cnt_q[SW-1:0];
		enq_row  = found ? row_q[pos[SW-1:0]] : new_row;
	end

	// queue counters at the selected queue
	always_comb begin
		tr_row   = row_q[slot_q];
		f_row    = cmd.chk ? tr_row : qa_row_q;
		f_prio   = cmd.chk ? '0 : qa_prio_q;
		fill_cur = fill_q[f_row][f_prio];
		full_cur = (32'(fill_cur) >= 32'(cap_q)) || (32'(fill_cur) >= QUEUE_DEPTH);
		head_cur = head_q[qa_row_q][qa_prio_q];
		tail_cur = tail_q[qa_row_q][qa_prio_q];
		head_nxt = (32'(head_cur) == QUEUE_DEPTH - 1) ? '0 : head_cur + DW'(1);
		tail_nxt = (32'(tail_cur) == QUEUE_DEPTH - 1) ? '0 : tail_cur + DW'(1);
	end

	// round-robin pick among nonempty slots at the scanned priority
	always_comb begin
		win_hi  = '0;
		win_any = '0;
		hit_hi  = 1'b0;
		hit_any = 1'b0;
		for (int s = 0; s < N; s++) begin
			cand[s] = (CW'(s) < cnt_q) && ne_q[row_q[s]][prio_q];
		end
		for (int s = N - 1; s >= 0; s--) begin
			if (cand[s]) begin
				win_any = SW'(s);
				hit_any = 1'b1;
				if (SW'(s) >= rr_q) begin
					win_hi = SW'(s);
					hit_hi = 1'b1;
				end
			end
		end
		win = hit_hi ? win_hi : win_any;
	end

	// highest-numbered nonempty low priority of the current slot
	always_comb begin
		psel = '0;
		pany = 1'b0;
		for (int p = 1; p < NPRIO; p++) begin
			if (ne_q[tr_row][p]) begin
				psel = PW'(p);
				pany = 1'b1;
			end
		end
		last_slot = ((CW'(slot_q) + CW'(1)) == cnt_q);
		moved_nxt = (moved_q == 4'd15) ? 4'd15 : moved_q + 4'd1;
	end

	// status to the controller
	always_comb begin
		sts.kind        = in_q.kind;
		sts.enable      = enable_q;
		sts.cnt_zero    = (cnt_q == '0);
		sts.new_id_full = !found && tbl_full;
		sts.q_full      = full_cur;
		sts.hit         = hit_any;
		sts.event_ok    = in_q.event_available;
		sts.last_prio   = (prio_q == PW'(LOWEST_PRIO));
		sts.tr_skip     = full_cur || !pany;
		sts.last_slot   = last_slot;
	end

	// queue storage access
	assign ram_we    = (cmd.op == prrq_pkg::OP_ENQ_PUSH) || (cmd.op == prrq_pkg::OP_TR_PUSH);
	assign ram_re    = (cmd.op == prrq_pkg::OP_SRV_POP) || (cmd.op == prrq_pkg::OP_TR_POP);
	assign ram_waddr = {qa_row_q, qa_prio_q, tail_cur};
	assign ram_raddr = {qa_row_q, qa_prio_q, head_cur};
	assign ram_wdata = (cmd.op == prrq_pkg::OP_ENQ_PUSH) ?
		{in_q.request_count, in_q.request_tag} : ram_rdata;

	prrq_ram #(
		.WIDTH(32),
		.DEPTH(1 << AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// build the result of a finishing transaction
	always_comb begin
		res_d        = '0;
		res_d.status = cmd.status;
		if (cmd.op == prrq_pkg::OP_SRV_GRANT) begin
			res_d.granted        = 1'b1;
			res_d.grant_id       = id_q[slot_q];
			res_d.grant_priority = 2'(qa_prio_q);
			res_d.grant_count    = ram_rdata[31:16];
			res_d.grant_tag      = ram_rdata[15:0];
		end
		if (in_q.kind == prrq_pkg::KIND_TR) begin
			res_d.moved_count = (cmd.op == prrq_pkg::OP_TR_PUSH) ? moved_nxt : moved_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			result <= res_d;
		end
		unique case (cmd.op)
			prrq_pkg::OP_LATCH: begin
				in_q   <= item;
				slot_q <= '0;
				prio_q <= '0;
			end
			prrq_pkg::OP_ENQ_FIND: begin
				if (!found) begin
					for (int i = 1; i < N; i++) begin
						if ((CW'(i) > pos) && (CW'(i) <= cnt_q)) begin
							id_q[i]  <= id_q[i-1];
							row_q[i] <= row_q[i-1];
						end
					end
					id_q[pos[SW-1:0]]  <= in_q.requester_id;
					row_q[pos[SW-1:0]] <= new_row;
				end
				qa_row_q  <= enq_row;
				qa_prio_q <= p_sat;
			end
			prrq_pkg::OP_SRV_NEXT: prio_q <= prio_q + PW'(1);
			prrq_pkg::OP_SRV_SEL: begin
				slot_q    <= win;
				qa_row_q  <= row_q[win];
				qa_prio_q <= prio_q;
			end
			prrq_pkg::OP_TR_NEXT: slot_q <= slot_q + SW'(1);
			prrq_pkg::OP_TR_SEL: begin
				qa_row_q  <= tr_row;
				qa_prio_q <= psel;
			end
			prrq_pkg::OP_TR_POP: qa_prio_q <= '0;
			prrq_pkg::OP_TR_PUSH: slot_q <= slot_q + SW'(1);
			default: ;
		endcase
	end

	// control registers: config, table count, pointer, queue counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			cap_q    <= prrq_pkg::CAP_RESET;
			cnt_q    <= '0;
			rr_q     <= '0;
			moved_q  <= '0;
			done     <= 1'b0;
			for (int r = 0; r < N; r++) begin
				ne_q[r] <= '0;
				for (int p = 0; p < NPRIO; p++) begin
					head_q[r][p] <= '0;
					tail_q[r][p] <= '0;
					fill_q[r][p] <= '0;
				end
			end
		end else begin
			done <= cmd.fin;
			if (cfg_we) begin
				unique case (cfg_index)
					prrq_pkg::REG_ENABLE:   enable_q <= cfg_data[0];
					prrq_pkg::REG_CAPACITY: cap_q    <= cfg_data;
					default: ;
				endcase
			end
			unique case (cmd.op)
				prrq_pkg::OP_LATCH: moved_q <= '0;
				prrq_pkg::OP_ENQ_FIND: begin
					if (!found) begin
						cnt_q <= cnt_q + CW'(1);
						rr_q  <= pos[SW-1:0];
					end
				end
				prrq_pkg::OP_SRV_MISS: rr_q <= win;
				prrq_pkg::OP_SRV_POP, prrq_pkg::OP_TR_POP: begin
					head_q[qa_row_q][qa_prio_q] <= head_nxt;
					fill_q[qa_row_q][qa_prio_q] <= fill_cur - FW'(1);
					ne_q[qa_row_q][qa_prio_q]   <= (fill_cur != FW'(1));
					if (cmd.op == prrq_pkg::OP_SRV_POP) begin
						rr_q <= last_slot ? '0 : slot_q + SW'(1);
					end
				end
				prrq_pkg::OP_ENQ_PUSH, prrq_pkg::OP_TR_PUSH: begin
					tail_q[qa_row_q][qa_prio_q] <= tail_nxt;
					fill_q[qa_row_q][qa_prio_q] <= fill_cur + FW'(1);
					ne_q[qa_row_q][qa_prio_q]   <= 1'b1;
					if (cmd.op == prrq_pkg::OP_TR_PUSH) begin
						moved_q <= moved_nxt;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### hw/rtl/prrq_chk.sv
// Port-level checker for the request queues, bound to the top level.
module prrq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input prrq_pkg::result_t result
);
	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");

	// a result is shown only once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// a grant always reports success
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.granted) |-> (result.status == prrq_pkg::ST_OK))
		else $error("grant with error status");

	// promotions never come with a grant or an error
	a_moved_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.moved_count != 4'd0)) |->
		(!result.granted && (result.status == prrq_pkg::ST_OK)))
		else $error("promotion result malformed");
endmodule

bind priority_round_robin_request_queues prrq_chk u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
